@@ sv/ccp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types, widths and register map for the perspective projection block.
// ----------------------------------------------------------------------------
package ccp_pkg;

    // pipeline depth of each part
    localparam int XF_STG = 5;
    localparam int SC_STG = 3;
    localparam int DV_STG = 19;
    localparam int N_STG  = XF_STG + SC_STG + DV_STG;

    localparam int NW  = 66;   // camera-space numerators and depth
    localparam int DTW = 49;   // basis determinant
    localparam int PW  = 100;  // projection numerator
    localparam int DDW = 81;   // depth shifted by 16

    // register map, index = paddr[5:3]
    localparam logic [2:0] REG_BASIS_I = 3'd0;
    localparam logic [2:0] REG_BASIS_J = 3'd1;
    localparam logic [2:0] REG_BASIS_K = 3'd2;
    localparam logic [2:0] REG_POS_X   = 3'd3;
    localparam logic [2:0] REG_POS_Y   = 3'd4;
    localparam logic [2:0] REG_POS_Z   = 3'd5;
    localparam logic [2:0] REG_FOCAL   = 3'd6;
    localparam logic [2:0] REG_CENTER  = 3'd7;

    localparam logic [47:0] RST_BASIS_I = 48'h0000_0000_4000;
    localparam logic [47:0] RST_BASIS_J = 48'h0000_4000_0000;
    localparam logic [47:0] RST_BASIS_K = 48'h4000_0000_0000;
    localparam logic [31:0] RST_FOCAL   = 32'h0000_C000;

    typedef struct packed {
        logic [2:0][47:0] basis;
        logic [2:0][31:0] pos;
        logic [31:0]      focal;
        logic [31:0]      center;
    } t_ccp_cfg;

    // camera-space word after sign fix-up
    typedef struct packed {
        logic signed [NW-1:0] numx;
        logic signed [NW-1:0] numy;
        logic signed [NW-1:0] den;
        logic                 behind;
        logic                 singular;
    } t_ccp_proj;

    // scaled numerators ready for division
    typedef struct packed {
        logic signed [PW-1:0] nx;
        logic signed [PW-1:0] ny;
        logic [DDW-1:0]       dd;
        logic                 behind;
        logic                 singular;
    } t_ccp_num;

endpackage

@@ sv/ccp_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_cfg
// APB register file: camera basis, position, focal scale and screen center.
// ----------------------------------------------------------------------------
module ccp_cfg import ccp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_ccp_cfg    o_cfg
);

    t_ccp_cfg   r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.basis[0] <= RST_BASIS_I;
            r_cfg.basis[1] <= RST_BASIS_J;
            r_cfg.basis[2] <= RST_BASIS_K;
            r_cfg.pos      <= '0;
            r_cfg.focal    <= RST_FOCAL;
            r_cfg.center   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BASIS_I: r_cfg.basis[0] <= pwdata[47:0];
                REG_BASIS_J: r_cfg.basis[1] <= pwdata[47:0];
                REG_BASIS_K: r_cfg.basis[2] <= pwdata[47:0];
                REG_POS_X:   r_cfg.pos[0]   <= pwdata[31:0];
                REG_POS_Y:   r_cfg.pos[1]   <= pwdata[31:0];
                REG_POS_Z:   r_cfg.pos[2]   <= pwdata[31:0];
                REG_FOCAL:   r_cfg.focal    <= pwdata[31:0];
                REG_CENTER:  r_cfg.center   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_BASIS_I: prdata = {16'b0, r_cfg.basis[0]};
            REG_BASIS_J: prdata = {16'b0, r_cfg.basis[1]};
            REG_BASIS_K: prdata = {16'b0, r_cfg.basis[2]};
            REG_POS_X:   prdata = {32'b0, r_cfg.pos[0]};
            REG_POS_Y:   prdata = {32'b0, r_cfg.pos[1]};
            REG_POS_Z:   prdata = {32'b0, r_cfg.pos[2]};
            REG_FOCAL:   prdata = {32'b0, r_cfg.focal};
            REG_CENTER:  prdata = {32'b0, r_cfg.center};
            default:     prdata = '0;
        endcase
    end

endmodule

@@ sv/ccp_xform.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_xform
// World to camera space: offset, cross products, adjugate dot products,
// determinant and sign fix-up, five register stages.
// ----------------------------------------------------------------------------
module ccp_xform import ccp_pkg::*; (
    input  logic               i_clk,
    input  logic [XF_STG-1:0]  i_en,
    input  t_ccp_cfg           i_cfg,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output t_ccp_proj          o_proj
);

    logic signed [15:0]    w_a [3][3];
    logic signed [31:0]    w_pt [3];

    logic signed [32:0]    r_d1 [3];
    logic signed [31:0]    r_p [3][6];
    logic signed [32:0]    r_d2 [3];
    logic signed [32:0]    r_cr [3][3];
    logic signed [NW-1:0]  r_pr [3][3];
    logic signed [DTW-1:0] r_dp [3];
    logic signed [NW-1:0]  r_n [3];
    logic signed [DTW-1:0] r_det;
    t_ccp_proj             n_proj;
    t_ccp_proj             r_proj;

    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                w_a[r][k] = $signed(i_cfg.basis[r][16*k +: 16]);
            end
        end
    end

    // offset and the 16x16 products of the cross terms
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int r = 0; r < 3; r++) begin
                r_d1[r]   <= 33'(w_pt[r]) - 33'($signed(i_cfg.pos[r]));
                r_p[r][0] <= w_a[(r+1)%3][1] * w_a[(r+2)%3][2];
                r_p[r][1] <= w_a[(r+1)%3][2] * w_a[(r+2)%3][1];
                r_p[r][2] <= w_a[(r+1)%3][2] * w_a[(r+2)%3][0];
                r_p[r][3] <= w_a[(r+1)%3][0] * w_a[(r+2)%3][2];
                r_p[r][4] <= w_a[(r+1)%3][0] * w_a[(r+2)%3][1];
                r_p[r][5] <= w_a[(r+1)%3][1] * w_a[(r+2)%3][0];
            end
        end
    end

    // cross products: row 0 = j x k, row 1 = k x i, row 2 = i x j
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int r = 0; r < 3; r++) begin
                r_d2[r] <= r_d1[r];
                for (int c = 0; c < 3; c++) begin
                    r_cr[r][c] <= 33'(r_p[r][2*c]) - 33'(r_p[r][2*c+1]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_pr[c][r] <= NW'(r_d2[r]) * NW'(r_cr[c][r]);
                end
                r_dp[c] <= DTW'(w_a[0][c]) * DTW'(r_cr[0][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            for (int c = 0; c < 3; c++) begin
                r_n[c] <= r_pr[c][0] + r_pr[c][1] + r_pr[c][2];
            end
            r_det <= r_dp[0] + r_dp[1] + r_dp[2];
        end
    end

    // depth sign must match the determinant; flip all three whenever the depth is negative
    always_comb begin
        n_proj.singular = (r_det == '0);
        n_proj.behind   = !n_proj.singular
                          && ((r_n[1] == '0) || (r_n[1][NW-1] != r_det[DTW-1]));
        if (r_n[1][NW-1]) begin
            n_proj.numx = -r_n[0];
            n_proj.numy = r_n[2];
            n_proj.den  = -r_n[1];
        end else begin
            n_proj.numx = r_n[0];
            n_proj.numy = -r_n[2];
            n_proj.den  = r_n[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_proj <= n_proj;
        end
    end

    assign o_proj = r_proj;

endmodule

@@ sv/ccp_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_scale
// Forms center * depth * 2^16 + focal * numerator for both axes with split
// partial products, three register stages.
// ----------------------------------------------------------------------------
module ccp_scale import ccp_pkg::*; (
    input  logic              i_clk,
    input  logic [SC_STG-1:0] i_en,
    input  t_ccp_cfg          i_cfg,
    input  t_ccp_proj         i_proj,
    output t_ccp_num          o_num
);

    logic signed [NW-1:0] w_num [2];
    logic signed [15:0]   w_ctr [2];
    logic signed [32:0]   w_focal;

    logic [64:0]          r_fl [2];
    logic signed [65:0]   r_fh [2];
    logic signed [49:0]   r_cl [2];
    logic signed [48:0]   r_ch [2];
    logic [NW-1:0]        r_den6;
    logic [1:0]           r_flg6;

    logic signed [PW-1:0] r_f [2];
    logic signed [81:0]   r_c [2];
    logic [DDW-1:0]       r_dd7;
    logic [1:0]           r_flg7;

    t_ccp_num             r_num;

    assign w_num[0] = i_proj.numx;
    assign w_num[1] = i_proj.numy;
    assign w_ctr[0] = $signed(i_cfg.center[15:0]);
    assign w_ctr[1] = $signed(i_cfg.center[31:16]);
    assign w_focal  = $signed({1'b0, i_cfg.focal});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int a = 0; a < 2; a++) begin
                r_fl[a] <= 65'(w_num[a][32:0]) * 65'(i_cfg.focal);
                r_fh[a] <= 66'($signed(w_num[a][65:33])) * 66'(w_focal);
                r_cl[a] <= 50'(w_ctr[a]) * 50'($signed({1'b0, i_proj.den[32:0]}));
                r_ch[a] <= 49'(w_ctr[a]) * 49'($signed(i_proj.den[65:33]));
            end
            r_den6 <= i_proj.den;
            r_flg6 <= {i_proj.behind, i_proj.singular};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int a = 0; a < 2; a++) begin
                r_f[a] <= (PW'(r_fh[a]) <<< 33) + $signed(PW'(r_fl[a]));
                r_c[a] <= (82'(r_ch[a]) <<< 33) + 82'(r_cl[a]);
            end
            r_dd7  <= {r_den6[64:0], 16'b0};
            r_flg7 <= r_flg6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_num.nx       <= (PW'(r_c[0]) <<< 16) + r_f[0];
            r_num.ny       <= (PW'(r_c[1]) <<< 16) + r_f[1];
            r_num.dd       <= r_dd7;
            r_num.behind   <= r_flg7[1];
            r_num.singular <= r_flg7[0];
        end
    end

    assign o_num = r_num;

endmodule

@@ sv/ccp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_div
// Truncating division of both axes by the shifted depth, one quotient bit
// per stage, then saturation and the flag override into the output register.
// ----------------------------------------------------------------------------
module ccp_div import ccp_pkg::*; (
    input  logic               i_clk,
    input  logic [DV_STG-1:0]  i_en,
    input  t_ccp_num           i_num,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic               o_behind_camera,
    output logic               o_singular_basis,
    output logic               o_saturated
);

    localparam int NQ = DV_STG - 3;  // quotient bits below the full-scale bit

    typedef struct packed {
        logic [1:0][PW-1:0] m;
        logic [1:0]         neg;
        logic [1:0][NQ-1:0] q;
        logic [1:0]         full;
        logic [DDW-1:0]     dd;
        logic               behind;
        logic               singular;
    } t_ccp_dv;

    t_ccp_dv            r_st [DV_STG-1];
    t_ccp_dv            n_st0;
    t_ccp_dv            n_st1;

    logic signed [15:0] r_sx;
    logic signed [15:0] r_sy;
    logic               r_behind;
    logic               r_singular;
    logic               r_sat;

    // {saturated, value}
    function automatic logic [16:0] fmt_axis(logic [NQ:0] q, logic neg);
        logic [16:0] res;
        if (neg) begin
            if (q > 17'd32768) res = {1'b1, 16'h8000};
            else               res = {1'b0, 16'(-q)};
        end else begin
            if (q > 17'd32767) res = {1'b1, 16'h7FFF};
            else               res = {1'b0, q[15:0]};
        end
        return res;
    endfunction

    // magnitude
    always_comb begin
        n_st0          = '0;
        n_st0.dd       = i_num.dd;
        n_st0.behind   = i_num.behind;
        n_st0.singular = i_num.singular;
        n_st0.neg[0]   = i_num.nx[PW-1];
        n_st0.neg[1]   = i_num.ny[PW-1];
        n_st0.m[0]     = i_num.nx[PW-1] ? PW'(-i_num.nx) : PW'(i_num.nx);
        n_st0.m[1]     = i_num.ny[PW-1] ? PW'(-i_num.ny) : PW'(i_num.ny);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) r_st[0] <= n_st0;
    end

    // quotient reaches full scale
    always_comb begin
        n_st1 = r_st[0];
        for (int a = 0; a < 2; a++) begin
            n_st1.full[a] = (r_st[0].m[a] >= (PW'(r_st[0].dd) << NQ));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) r_st[1] <= n_st1;
    end

    for (genvar s = 2; s < DV_STG - 1; s++) begin : g_step
        localparam int B = DV_STG - 2 - s;
        t_ccp_dv        n_st;
        logic [PW-1:0]  w_t;

        assign w_t = PW'(r_st[s-1].dd) << B;

        always_comb begin
            n_st = r_st[s-1];
            for (int a = 0; a < 2; a++) begin
                if (r_st[s-1].m[a] >= w_t) begin
                    n_st.m[a]    = r_st[s-1].m[a] - w_t;
                    n_st.q[a][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) r_st[s] <= n_st;
        end
    end

    logic [NQ:0]  w_qx;
    logic [NQ:0]  w_qy;
    logic [16:0]  w_fx;
    logic [16:0]  w_fy;
    logic         w_zero;
    t_ccp_dv      w_last;

    assign w_last = r_st[DV_STG-2];
    assign w_qx   = w_last.full[0] ? {1'b1, NQ'(0)} : {1'b0, w_last.q[0]};
    assign w_qy   = w_last.full[1] ? {1'b1, NQ'(0)} : {1'b0, w_last.q[1]};
    assign w_fx   = fmt_axis(w_qx, w_last.neg[0]);
    assign w_fy   = fmt_axis(w_qy, w_last.neg[1]);
    assign w_zero = w_last.singular || w_last.behind;

    always_ff @(posedge i_clk) begin
        if (i_en[DV_STG-1]) begin
            r_sx       <= w_zero ? '0 : $signed(w_fx[15:0]);
            r_sy       <= w_zero ? '0 : $signed(w_fy[15:0]);
            r_sat      <= !w_zero && (w_fx[16] || w_fy[16]);
            r_behind   <= w_last.behind;
            r_singular <= w_last.singular;
        end
    end

    assign o_screen_x       = r_sx;
    assign o_screen_y       = r_sy;
    assign o_behind_camera  = r_behind;
    assign o_singular_basis = r_singular;
    assign o_saturated      = r_sat;

endmodule

@@ sv/camera_perspective_projection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_perspective_projection
// Projects one Q16.16 world point per word onto 16-bit screen coordinates.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  input    | i_valid / o_stall       | i_point_x, i_point_y, i_point_z
//  output   | o_valid / i_stall       | o_screen_x/y, flags
//  config   | psel/penable/pwrite     | paddr (8*index), pwdata, prdata
//
// one word per cycle while no stage holds; the multiply stages are followed by
// the 17 one-bit division stages
// each stage holds only when it is full and the stage after it holds, so
// bubbles close up and input is taken while a finished word waits
// synchronous active-low reset clears the valid bits and the configuration registers
// ----------------------------------------------------------------------------
module camera_perspective_projection import ccp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic               o_behind_camera,
    output logic               o_singular_basis,
    output logic               o_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    t_ccp_cfg         w_cfg;
    t_ccp_proj        w_proj;
    t_ccp_num         w_num;
    logic [N_STG-1:0] w_rdy;
    logic [N_STG-1:0] r_valid;

    always_comb begin
        w_rdy[N_STG-1] = !r_valid[N_STG-1] || !i_stall;
        for (int k = N_STG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_valid[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_rdy[0]) r_valid[0] <= i_valid;
            for (int k = 1; k < N_STG; k++) begin
                if (w_rdy[k]) r_valid[k] <= r_valid[k-1];
            end
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_valid[N_STG-1];

    ccp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ccp_xform u_xform (
        .i_clk     (i_clk),
        .i_en      (w_rdy[XF_STG-1:0]),
        .i_cfg     (w_cfg),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .o_proj    (w_proj)
    );

    ccp_scale u_scale (
        .i_clk  (i_clk),
        .i_en   (w_rdy[XF_STG+SC_STG-1:XF_STG]),
        .i_cfg  (w_cfg),
        .i_proj (w_proj),
        .o_num  (w_num)
    );

    ccp_div u_div (
        .i_clk            (i_clk),
        .i_en             (w_rdy[N_STG-1:XF_STG+SC_STG]),
        .i_num            (w_num),
        .o_screen_x       (o_screen_x),
        .o_screen_y       (o_screen_y),
        .o_behind_camera  (o_behind_camera),
        .o_singular_basis (o_singular_basis),
        .o_saturated      (o_saturated)
    );

endmodule

@@ dv/ccp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_checker
// Watches the point, screen and register ports of the projection block,
// keeps its own copy of the registers, predicts each projected word and
// compares it field by field against the block's output in arrival order.
// ----------------------------------------------------------------------------
module ccp_checker import ccp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [15:0] o_screen_x,
    input  logic signed [15:0] o_screen_y,
    input  logic               o_behind_camera,
    input  logic               o_singular_basis,
    input  logic               o_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    input  logic               pready,
    output int                 o_pending,
    output int                 o_errors
);

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               behind;
        logic               singular;
        logic               sat;
    } t_screen;

    logic [47:0]        cam_basis [3];
    logic signed [31:0] cam_pos [3];
    logic [31:0]        cam_focal;
    logic [31:0]        cam_center;
    t_screen            screen_q [$];

    assign o_pending = screen_q.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    // trunc(center + focal * num / den), den > 0, clamped to 16 bits
    function automatic logic signed [15:0] scale_axis(input logic signed [15:0] ctr,
        input logic signed [159:0] num, input logic signed [159:0] den,
        inout logic sat);
        logic signed [159:0] fz, cz, acc, mag, dd, q;
        fz  = {128'b0, cam_focal};
        cz  = ctr;
        dd  = den <<< 16;
        acc = cz * dd + num * fz;
        mag = (acc < 0) ? -acc : acc;
        q   = (mag >= (dd <<< 16)) ? 160'sd65536 : mag / dd;
        if (acc < 0) begin
            if (q > 32768) begin
                sat = 1'b1;
                return 16'sh8000;
            end
            return 16'(-q);
        end
        if (q > 32767) begin
            sat = 1'b1;
            return 16'sh7fff;
        end
        return 16'(q);
    endfunction

    function automatic t_screen project_point(input logic signed [31:0] px,
        input logic signed [31:0] py, input logic signed [31:0] pz);
        logic signed [15:0]  a [3][3];
        logic signed [63:0]  cr [3][3];
        logic signed [63:0]  det;
        logic signed [159:0] dv [3];
        logic signed [159:0] nn [3];
        int                  u, v;
        t_screen             s;
        s = '0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                a[r][c] = cam_basis[r][16*c +: 16];
        dv[0] = px;
        dv[1] = py;
        dv[2] = pz;
        for (int r = 0; r < 3; r++) begin
            dv[r] = dv[r] - cam_pos[r];
        end
        // rows of the adjugate: j x k, k x i, i x j
        for (int r = 0; r < 3; r++) begin
            u = (r + 1) % 3;
            v = (r + 2) % 3;
            cr[r][0] = 64'(a[u][1]) * a[v][2] - 64'(a[u][2]) * a[v][1];
            cr[r][1] = 64'(a[u][2]) * a[v][0] - 64'(a[u][0]) * a[v][2];
            cr[r][2] = 64'(a[u][0]) * a[v][1] - 64'(a[u][1]) * a[v][0];
        end
        det = a[0][0] * cr[0][0] + a[0][1] * cr[0][1] + a[0][2] * cr[0][2];
        for (int c = 0; c < 3; c++)
            nn[c] = dv[0] * cr[c][0] + dv[1] * cr[c][1] + dv[2] * cr[c][2];
        if (det == 0) begin
            s.singular = 1'b1;
        end else if (nn[1] == 0 || ((nn[1] < 0) != (det < 0))) begin
            s.behind = 1'b1;
        end else begin
            if (nn[1] < 0) begin
                for (int c = 0; c < 3; c++) nn[c] = -nn[c];
            end
            s.sx = scale_axis(cam_center[15:0], nn[0], nn[1], s.sat);
            s.sy = scale_axis(cam_center[31:16], -nn[2], nn[1], s.sat);
        end
        return s;
    endfunction

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_screen want;
        if (!i_rst_n) begin
            cam_basis[0] = RST_BASIS_I;
            cam_basis[1] = RST_BASIS_J;
            cam_basis[2] = RST_BASIS_K;
            for (int r = 0; r < 3; r++) cam_pos[r] = '0;
            cam_focal  = RST_FOCAL;
            cam_center = '0;
            screen_q.delete();
        end else begin
            if (o_valid && !i_stall) begin
                if (screen_q.size() == 0) begin
                    $display("unexpected output word at %0t", $realtime);
                    o_errors++;
                end else begin
                    want = screen_q.pop_front();
                    if (o_screen_x !== want.sx) report("screen_x", o_screen_x, want.sx);
                    if (o_screen_y !== want.sy) report("screen_y", o_screen_y, want.sy);
                    if (o_behind_camera !== want.behind)
                        report("behind_camera", o_behind_camera, want.behind);
                    if (o_singular_basis !== want.singular)
                        report("singular_basis", o_singular_basis, want.singular);
                    if (o_saturated !== want.sat) report("saturated", o_saturated, want.sat);
                end
            end
            if (i_valid && !o_stall)
                screen_q.push_back(project_point(i_point_x, i_point_y, i_point_z));
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_BASIS_I: cam_basis[0] = pwdata[47:0];
                    REG_BASIS_J: cam_basis[1] = pwdata[47:0];
                    REG_BASIS_K: cam_basis[2] = pwdata[47:0];
                    REG_POS_X:   cam_pos[0]   = pwdata[31:0];
                    REG_POS_Y:   cam_pos[1]   = pwdata[31:0];
                    REG_POS_Z:   cam_pos[2]   = pwdata[31:0];
                    REG_FOCAL:   cam_focal    = pwdata[31:0];
                    REG_CENTER:  cam_center   = pwdata[31:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives world points and register settings into the projection block with
// random gaps and output stalls; a checker beside the block predicts and
// compares every screen word.
// ----------------------------------------------------------------------------
module tb;
    import ccp_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_point_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_screen_x;
    logic signed [15:0] o_screen_y;
    logic               o_behind_camera;
    logic               o_singular_basis;
    logic               o_saturated;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [5:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    int                 pending;
    int                 errors;
    int                 points_sent = 0;
    bit                 long_hold_done = 1'b0;

    always #10 i_clk = ~i_clk;

    camera_perspective_projection dut (.*);

    ccp_checker chk (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_point_x, .i_point_y, .i_point_z,
        .o_valid, .i_stall, .o_screen_x, .o_screen_y, .o_behind_camera,
        .o_singular_basis, .o_saturated, .psel, .penable, .pwrite, .paddr,
        .pwdata, .pready, .o_pending(pending), .o_errors(errors)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return to idle between transfers
        @(posedge i_clk);
    endtask

    // offer one word; returns just after the edge that took it, or after a random gap when gaps is set
    task automatic offer_point(input logic [31:0] x, input logic [31:0] y,
        input logic [31:0] z, input bit gaps);
        int g;
        i_valid   <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        points_sent++;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] coord(input logic [31:0] near);
        int r;
        r = $urandom_range(99);
        if (r < 55) return near + $signed($urandom_range(0, 1 << 23)) - (1 << 22);
        if (r < 85) return $urandom;
        case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [15:0] comp();
        int r;
        r = $urandom_range(9);
        if (r < 3) return 16'h0000;
        if (r == 3) return 16'h7fff;
        if (r == 4) return 16'h8000;
        return 16'($urandom);
    endfunction

    logic [31:0] base_pos [3];

    task automatic load_phase(input int ph);
        logic [47:0] bi, bj, bk;
        logic [31:0] foc, ctr;
        bi = {comp(), comp(), comp()};
        bj = {comp(), comp(), comp()};
        bk = {comp(), comp(), comp()};
        for (int r = 0; r < 3; r++) base_pos[r] = $urandom_range(0, 1 << 24) - (1 << 23);
        foc = $urandom_range(1 << 12, 1 << 20);
        ctr = $urandom;
        case (ph)
            1: begin
                bi = 48'h0000_0000_7fff;
                bj = 48'h0000_8000_0000;
                bk = 48'h7fff_0000_0000;
                base_pos[0] = 32'h7fff_ffff;
                base_pos[1] = 32'h8000_0000;
                base_pos[2] = 32'h8000_0000;
                foc = 32'hffff_ffff;
                ctr = 32'h8000_7fff;
            end
            2: begin
                bk  = bi;
                foc = 32'h0000_0000;
                ctr = 32'h0000_0000;
            end
            3: begin
                bi = 48'h0000_0000_4000;
                bj = 48'h0000_4000_0000;
                bk = 48'h4000_0000_0000;
                foc = 32'h0001_0000;
                ctr = 32'h7fff_8000;
            end
            4: begin
                bi = 48'h0000_0800_3c00;
                bj = 48'h0000_3c00_f800;
                bk = 48'h4000_0000_0000;
            end
            default: ;
        endcase
        reg_write(REG_BASIS_I, {16'h0, bi});
        reg_write(REG_BASIS_J, {16'h0, bj});
        reg_write(REG_BASIS_K, {16'h0, bk});
        reg_write(REG_POS_X, {32'h0, base_pos[0]});
        reg_write(REG_POS_Y, {32'h0, base_pos[1]});
        reg_write(REG_POS_Z, {32'h0, base_pos[2]});
        reg_write(REG_FOCAL, {32'h0, foc});
        reg_write(REG_CENTER, {32'h0, ctr});
    endtask

    // output stalls, one long hold-off while the sender keeps going
    initial begin
        int r;
        bit quiet;
        quiet = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && points_sent > 300) begin
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            if ($urandom_range(199) == 0) quiet = ~quiet;
            r = $urandom_range(99);
            if (quiet || r < 70) begin
                i_stall <= 1'b0;
            end else if (r < 95) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 3)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(8, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #60ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [31:0] vx, vy, vz;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed words on the reset basis
        offer_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        offer_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        offer_point(32'h0000_0000, 32'hffff_0000, 32'h0000_0000, 1'b0);
        offer_point(32'h7fff_ffff, 32'h0000_0001, 32'h0000_0000, 1'b0);
        offer_point(32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 1'b0);
        offer_point(32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff, 1'b0);
        offer_point(32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 1'b0);
        offer_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        offer_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        offer_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        offer_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        offer_point(32'h0003_0000, 32'h0004_0000, 32'hfffd_0000, 1'b0);
        offer_point(32'hfffe_8000, 32'h0000_8000, 32'h0001_8000, 1'b0);
        offer_point(32'h5555_5555, 32'h2aaa_aaaa, 32'haaaa_aaaa, 1'b0);
        i_valid <= 1'b0;
        for (int ph = 0; ph < 8; ph++) begin
            wait (pending == 0);
            repeat (40) @(posedge i_clk);
            load_phase(ph < 5 ? ph + 1 : 0);
            for (int n = 0; n < 168; n++) begin
                vx = coord(base_pos[0]);
                vy = coord(base_pos[1]);
                vz = coord(base_pos[2]);
                offer_point(vx, vy, vz, 1'b1);
            end
            i_valid <= 1'b0;
        end
        wait (pending == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ccp_pkg.sv
sv/ccp_cfg.sv
sv/ccp_xform.sv
sv/ccp_scale.sv
sv/ccp_div.sv
sv/camera_perspective_projection.sv
dv/ccp_checker.sv
dv/tb.sv
